// File: rtl/box_overlap_ratio_top_defines.svh
// Assertion macros shared by the box overlap ratio RTL
`ifndef BOX_OVERLAP_RATIO_TOP_DEFINES_SVH
`define BOX_OVERLAP_RATIO_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define BOR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define BOR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BOR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BOR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/bor_pkg.sv
// Package of shared constants for the box overlap ratio block
`default_nettype none
package bor_pkg;
  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COORD_BITS_MIN    = 8;
  localparam int FRACTION_BITS_MIN = 8;
endpackage
`default_nettype wire

// File: rtl/bor_geom.sv
// Intersection geometry and area pipeline: edges, clamped extents, products, smaller area
`default_nettype none
module bor_geom #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic signed [COORD_BITS-1:0] first_x,
  input  wire logic signed [COORD_BITS-1:0] first_y,
  input  wire logic [COORD_BITS-2:0]        first_width,
  input  wire logic [COORD_BITS-2:0]        first_height,
  input  wire logic signed [COORD_BITS-1:0] second_x,
  input  wire logic signed [COORD_BITS-1:0] second_y,
  input  wire logic [COORD_BITS-2:0]        second_width,
  input  wire logic [COORD_BITS-2:0]        second_height,
  output logic                              out_valid,
  output logic [2*COORD_BITS-3:0]           num,
  output logic [2*COORD_BITS-3:0]           den
);
  localparam int SW = COORD_BITS - 1;
  localparam int AW = 2 * SW;
  localparam int EW = COORD_BITS + 1;

  // stage 1: edges
  logic signed [EW-1:0] ax, ay, bx, by, ar, ab, br, bb;
  logic signed [EW-1:0] left_nxt, right_nxt, top_nxt, bottom_nxt;
  logic signed [EW-1:0] left_r, right_r, top_r, bottom_r;
  logic [SW-1:0]        aw1_r, ah1_r, bw1_r, bh1_r;
  logic                 v1_r;

  // stage 2: clamped intersection extents
  logic signed [EW:0]   dx, dy;
  logic [SW-1:0]        iw_nxt, ih_nxt;
  logic [SW-1:0]        iw_r, ih_r, aw2_r, ah2_r, bw2_r, bh2_r;
  logic                 v2_r;

  // stage 3: areas
  logic [AW-1:0]        area_a_r, area_b_r, inter_r;
  logic                 v3_r;

  // stage 4: divisor select
  logic [AW-1:0]        smaller;
  logic [AW-1:0]        num_r, den_r;
  logic                 v4_r;

  always_comb begin
    ax = EW'(first_x);
    ay = EW'(first_y);
    bx = EW'(second_x);
    by = EW'(second_y);
    ar = ax + $signed({2'b00, first_width});
    ab = ay + $signed({2'b00, first_height});
    br = bx + $signed({2'b00, second_width});
    bb = by + $signed({2'b00, second_height});
    left_nxt   = (ax > bx) ? ax : bx;
    top_nxt    = (ay > by) ? ay : by;
    right_nxt  = (ar < br) ? ar : br;
    bottom_nxt = (ab < bb) ? ab : bb;
  end

  always_comb begin
    dx = $signed({right_r[EW-1], right_r}) - $signed({left_r[EW-1], left_r});
    dy = $signed({bottom_r[EW-1], bottom_r}) - $signed({top_r[EW-1], top_r});
    // an empty or touching overlap gives zero extent
    iw_nxt = (right_r > left_r) ? dx[SW-1:0] : '0;
    ih_nxt = (bottom_r > top_r) ? dy[SW-1:0] : '0;
  end

  // the overlap never exceeds either area, so a zero smaller area pairs with a
  // zero numerator; force a divisor of one there to yield a zero quotient
  always_comb begin
    smaller = (area_a_r < area_b_r) ? area_a_r : area_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      aw1_r    <= first_width;
      ah1_r    <= first_height;
      bw1_r    <= second_width;
      bh1_r    <= second_height;

      iw_r  <= iw_nxt;
      ih_r  <= ih_nxt;
      aw2_r <= aw1_r;
      ah2_r <= ah1_r;
      bw2_r <= bw1_r;
      bh2_r <= bh1_r;

      area_a_r <= AW'(aw2_r) * AW'(ah2_r);
      area_b_r <= AW'(bw2_r) * AW'(bh2_r);
      inter_r  <= AW'(iw_r) * AW'(ih_r);

      num_r <= inter_r;
      den_r <= (smaller == '0) ? AW'(1) : smaller;
    end
  end

  assign out_valid = v4_r;
  assign num       = num_r;
  assign den       = den_r;
endmodule
`default_nettype wire

// File: rtl/bor_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage
`default_nettype none
module bor_div #(
  parameter int NUM_BITS = 30,
  parameter int Q_BITS   = 17
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [NUM_BITS-1:0] den,
  output logic                     out_valid,
  output logic [Q_BITS-1:0]        quot
);
  logic [NUM_BITS-1:0] rem_r [Q_BITS];
  logic [NUM_BITS-1:0] den_r [Q_BITS];
  logic [Q_BITS-1:0]   q_r   [Q_BITS];
  logic                v_r   [Q_BITS];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    logic [NUM_BITS:0]   part;
    logic [NUM_BITS:0]   diff;
    logic [NUM_BITS-1:0] d_in;
    logic [Q_BITS-1:0]   q_in;
    logic                v_in;
    logic                bit_q;

    // the first stage yields the integer bit, the rest shift in fraction bits
    if (i == 0) begin : g_first
      assign part = {1'b0, num};
      assign d_in = den;
      assign q_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign part = {rem_r[i-1], 1'b0};
      assign d_in = den_r[i-1];
      assign q_in = q_r[i-1];
      assign v_in = v_r[i-1];
    end

    assign diff  = part - {1'b0, d_in};
    assign bit_q = (part >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= bit_q ? diff[NUM_BITS-1:0] : part[NUM_BITS-1:0];
        den_r[i] <= d_in;
        q_r[i]   <= {q_in[Q_BITS-2:0], bit_q};
      end
    end
  end

  assign out_valid = v_r[Q_BITS-1];
  assign quot      = q_r[Q_BITS-1];
endmodule
`default_nettype wire

// File: rtl/box_overlap_ratio_top.sv
// Top level of the box overlap ratio block: stream ports, pipeline control, output register
//
// Use: each input beat carries two axis-aligned boxes (signed origin plus
// unsigned size). The block returns, per beat, the overlap area divided by
// the smaller box area as unsigned fixed point with FRACTION_BITS fraction
// bits, truncated; 1 << FRACTION_BITS stands for full containment. A box of
// zero area, or boxes that only touch or lie apart, give zero.
// Channels: in_* carries box pairs, out_* carries ratios, one out beat per in
// beat, in order. No configuration.
// Pipeline: four geometry stages, FRACTION_BITS + 1 divider stages and one output
// register lie between accept and out_tvalid.
// Throughput: one beat per cycle while the pipeline advances; every divider stage
// resolves one quotient bit with its own subtractor, so a new pair can enter each
// cycle unless the output stalls.
// Stall: the whole pipeline advances only when the output register is empty
// or being taken, so in_tready drops while a result waits; nothing is lost or
// repeated. Reset clears every valid bit; payload registers are not reset.
`default_nettype none
`include "box_overlap_ratio_top_defines.svh"
module box_overlap_ratio_top
  import bor_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // first_x, first_y, first_width, first_height,
  // second_x, second_y, second_width, second_height (low to high), zero pad
  input  wire logic [((8*COORD_BITS-4+7)/8)*8-1:0]    in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // overlap (low bits), zero pad
  output logic [((FRACTION_BITS+1+7)/8)*8-1:0]        out_tdata
);
  localparam int C        = COORD_BITS;
  localparam int SW       = COORD_BITS - 1;
  localparam int AW       = 2 * SW;
  localparam int QW       = FRACTION_BITS + 1;
  localparam int OUT_BITS = ((FRACTION_BITS + 1 + 7) / 8) * 8;
  localparam logic [QW-1:0] ONE = QW'(1) << FRACTION_BITS;

  logic          advance;
  logic          geom_valid;
  logic [AW-1:0] geom_num, geom_den;
  logic          div_valid;
  logic [QW-1:0] div_quot;
  logic          out_tvalid_r;
  logic [QW-1:0] out_overlap_r;

  // advance everything together whenever the output slot is free or emptying
  assign advance   = !out_tvalid_r || out_tready;
  assign in_tready = advance;

  bor_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (advance),
    .in_valid      (in_tvalid),
    .first_x       ($signed(in_tdata[C-1:0])),
    .first_y       ($signed(in_tdata[2*C-1:C])),
    .first_width   (in_tdata[2*C+SW-1:2*C]),
    .first_height  (in_tdata[2*C+2*SW-1:2*C+SW]),
    .second_x      ($signed(in_tdata[3*C+2*SW-1:2*C+2*SW])),
    .second_y      ($signed(in_tdata[4*C+2*SW-1:3*C+2*SW])),
    .second_width  (in_tdata[4*C+3*SW-1:4*C+2*SW]),
    .second_height (in_tdata[4*C+4*SW-1:4*C+3*SW]),
    .out_valid     (geom_valid),
    .num           (geom_num),
    .den           (geom_den)
  );

  bor_div #(
    .NUM_BITS (AW),
    .Q_BITS   (QW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (geom_valid),
    .num       (geom_num),
    .den       (geom_den),
    .out_valid (div_valid),
    .quot      (div_quot)
  );

  // output register: load on advance, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (advance) begin
      out_tvalid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_overlap_r <= div_quot;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_BITS'(out_overlap_r);

  `BOR_ASSERT_IMP(a_ratio_range, clk, rst_n, out_tvalid_r, out_overlap_r <= ONE, "ratio above one")
  `BOR_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, out_tvalid_r && !out_tready, !in_tready, "input taken during output stall")
  `BOR_ASSERT_IMP(a_divisor_nonzero, clk, rst_n, geom_valid, geom_den != '0, "zero divisor entering divider")
  `BOR_ASSERT_NXT(a_result_loaded, clk, rst_n, advance && div_valid, out_tvalid_r, "divider result not loaded")
endmodule
`default_nettype wire
